// ===== hdl/ypm_pkg.sv =====
package ypm_pkg;

	localparam int DIM_W     = 13;
	localparam int FRAME_W   = 17;
	localparam int ACC_W     = 40;
	localparam int PSNR_W    = 15;
	localparam int PIX_W     = 8;
	localparam int PLANE_W   = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 17;
	localparam int MANT_W    = 31;
	localparam int FRAC_W    = 16;
	localparam int BIT_W     = 4;
	localparam int K_W       = 26;

	localparam int MAX_WIDTH_DEF  = 4096;
	localparam int MAX_HEIGHT_DEF = 4096;

	localparam logic [ACC_W-1:0]   ACC_MAX   = {ACC_W{1'b1}};
	localparam logic [FRAME_W-1:0] FRAME_MAX = {FRAME_W{1'b1}};
	localparam logic [PSNR_W-1:0]  PSNR_MAX  = {PSNR_W{1'b1}};
	localparam logic [15:0]        PEAK_SQ   = 16'd65025;
	localparam logic [K_W-1:0]     LOG_K     = 26'd50504453;

	localparam logic [PLANE_W-1:0] PLANE_Y = 2'd0;
	localparam logic [PLANE_W-1:0] PLANE_V = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LAST   = 2'd3;

	typedef struct packed {
		logic             busy;
		logic             ld_num;
		logic             shift;
		logic             take_m;
		logic             mul;
		logic             chk;
		logic             save_ln;
		logic             diff;
		logic             scale;
		logic [BIT_W-1:0] bitsel;
	} cmd_t;

	typedef struct packed {
		logic job_start;
		logic job_zero;
		logic x_msb;
	} sts_t;

endpackage

// ===== hdl/ypm_if.sv =====
interface ypm_pix_if;
	logic                     valid;
	logic                     ready;
	logic [ypm_pkg::PIX_W-1:0] orig_pixel;
	logic [ypm_pkg::PIX_W-1:0] rec_pixel;
	modport source (output valid, orig_pixel, rec_pixel, input ready);
	modport sink (input valid, orig_pixel, rec_pixel, output ready);
endinterface

interface ypm_res_if;
	logic                       valid;
	logic                       ready;
	logic [ypm_pkg::PLANE_W-1:0] plane_id;
	logic [ypm_pkg::FRAME_W-1:0] frame_index;
	logic [ypm_pkg::PSNR_W-1:0]  psnr_db_q8;
	logic [ypm_pkg::ACC_W-1:0]   square_error_sum;
	logic                        perfect_match;
	modport source (output valid, plane_id, frame_index, psnr_db_q8, square_error_sum,
		perfect_match, input ready);
	modport sink (input valid, plane_id, frame_index, psnr_db_q8, square_error_sum,
		perfect_match, output ready);
endinterface

// ===== hdl/yuv420_plane_psnr_meter_core.sv =====
// timing: a plane result is offered once log2 of peak*count and of the sse, each normalized
//   in the 41-bit log operand, are found; a plane with an error sum of zero is offered in the
//   cycle after its last pixel is accepted
// throughput: one pixel pair per cycle; the last pixel of a plane waits while the log
//   unit still holds the previous plane's result
// reset: arst_n clears control, config and counters; log unit and result regs are not reset
module yuv420_plane_psnr_meter_core #(
	parameter int MAX_WIDTH  = ypm_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = ypm_pkg::MAX_HEIGHT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	ypm_pix_if.sink                       pix,
	ypm_res_if.source                     res,
	input  logic                          cfg_we,
	input  logic [ypm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ypm_pkg::CFG_DAT_W-1:0] cfg_data
);

	// command and status between sequencer and datapath
	ypm_pkg::cmd_t cmd;
	ypm_pkg::sts_t sts;

	// sequencer: log2 of peak*count, then of sse, scale and hold; a zero sse goes to hold
	ypm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.sts       (sts),
		.res_ready (res.ready),
		.res_valid (res.valid),
		.cmd       (cmd)
	);

	// pixel accumulation, plane and frame counting, log datapath and result register
	ypm_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (pix.valid),
		.in_ready         (pix.ready),
		.orig_pixel       (pix.orig_pixel),
		.rec_pixel        (pix.rec_pixel),
		.cmd              (cmd),
		.sts              (sts),
		.plane_id         (res.plane_id),
		.frame_index      (res.frame_index),
		.psnr_db_q8       (res.psnr_db_q8),
		.square_error_sum (res.square_error_sum),
		.perfect_match    (res.perfect_match)
	);

endmodule

// ===== hdl/ypm_ctrl.sv =====
module ypm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  ypm_pkg::sts_t  sts,
	input  logic           res_ready,
	output logic           res_valid,
	output ypm_pkg::cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_LDN, S_NORM, S_MUL, S_CHK, S_NEXT, S_DIFF, S_SCALE, S_OUT
	} state_t;

	state_t                     state_q;
	logic [ypm_pkg::BIT_W-1:0]  bit_q;
	logic                       phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			bit_q     <= '0;
			phase_q   <= 1'b0;
			res_valid <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (sts.job_start) begin
						phase_q <= 1'b0;
						if (sts.job_zero) begin
							state_q   <= S_OUT;
							res_valid <= 1'b1;
						end else begin
							state_q <= S_LDN;
						end
					end
				end
				S_LDN: state_q <= S_NORM;
				S_NORM: begin
					if (sts.x_msb) begin
						bit_q   <= {ypm_pkg::BIT_W{1'b1}};
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_CHK;
				S_CHK: begin
					if (bit_q == '0) begin
						state_q <= phase_q ? S_DIFF : S_NEXT;
					end else begin
						bit_q   <= bit_q - 1'b1;
						state_q <= S_MUL;
					end
				end
				S_NEXT: begin
					phase_q <= 1'b1;
					state_q <= S_NORM;
				end
				S_DIFF: state_q <= S_SCALE;
				S_SCALE: begin
					state_q   <= S_OUT;
					res_valid <= 1'b1;
				end
				S_OUT: begin
					if (res_ready) begin
						state_q   <= S_IDLE;
						res_valid <= 1'b0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd         = '0;
		cmd.busy    = (state_q != S_IDLE);
		cmd.ld_num  = (state_q == S_LDN);
		cmd.shift   = (state_q == S_NORM) && !sts.x_msb;
		cmd.take_m  = (state_q == S_NORM) && sts.x_msb;
		cmd.mul     = (state_q == S_MUL);
		cmd.chk     = (state_q == S_CHK);
		cmd.save_ln = (state_q == S_NEXT);
		cmd.diff    = (state_q == S_DIFF);
		cmd.scale   = (state_q == S_SCALE);
		cmd.bitsel  = bit_q;
	end

endmodule

// ===== hdl/ypm_datapath.sv =====
module ypm_datapath #(
	parameter int MAX_WIDTH  = ypm_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = ypm_pkg::MAX_HEIGHT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ypm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ypm_pkg::CFG_DAT_W-1:0]   cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [ypm_pkg::PIX_W-1:0]       orig_pixel,
	input  logic [ypm_pkg::PIX_W-1:0]       rec_pixel,
	input  ypm_pkg::cmd_t                   cmd,
	output ypm_pkg::sts_t                   sts,
	output logic [ypm_pkg::PLANE_W-1:0]     plane_id,
	output logic [ypm_pkg::FRAME_W-1:0]     frame_index,
	output logic [ypm_pkg::PSNR_W-1:0]      psnr_db_q8,
	output logic [ypm_pkg::ACC_W-1:0]       square_error_sum,
	output logic                            perfect_match
);

	localparam int DIMX_W = ypm_pkg::DIM_W + 1;
	localparam int SIZE_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
	localparam int X_W    = (ypm_pkg::ACC_W > SIZE_W + 16) ? ypm_pkg::ACC_W : SIZE_W + 16;
	localparam int E_W    = $clog2(X_W);
	localparam int R_W    = E_W + ypm_pkg::FRAC_W;
	localparam int PROD_W = R_W + ypm_pkg::K_W;
	localparam int SQ_W   = 2 * ypm_pkg::MANT_W;
	localparam int RST_W  = (MAX_WIDTH < 176) ? MAX_WIDTH : 176;
	localparam int RST_H  = (MAX_HEIGHT < 144) ? MAX_HEIGHT : 144;

	logic [ypm_pkg::DIM_W-1:0]   w_q, h_q, w_src, h_src;
	logic [ypm_pkg::FRAME_W-1:0] last_q, frame_q;
	logic [ypm_pkg::PLANE_W-1:0] plane_q, plane_nx;
	logic [SIZE_W-1:0]           left_q, luma_sz, uv_sz, next_sz;
	logic [DIMX_W-1:0]           w_eff, h_eff;
	logic [ypm_pkg::ACC_W-1:0]   acc_q, acc_next;
	logic [ypm_pkg::ACC_W:0]     acc_sum;
	logic [ypm_pkg::PIX_W-1:0]   diff_pix;
	logic [15:0]                 sq;
	logic                        accept, last_pix, frame_ok, size_wr;

	// log unit
	logic [SIZE_W-1:0]           cnt_q;
	logic [X_W-1:0]              x_q;
	logic [E_W-1:0]              e_q;
	logic [ypm_pkg::MANT_W-1:0]  m_q;
	logic [SQ_W-1:0]             p_q;
	logic [R_W-1:0]              r_q, ln_q, d_val;
	logic [PROD_W-1:0]           prod_q;
	logic [PROD_W:0]             rnd;
	logic [31:0]                 t_sq;

	function automatic logic [DIMX_W-1:0] clampd(input logic [ypm_pkg::DIM_W-1:0] v,
		input logic [DIMX_W-1:0] hi);
		logic [DIMX_W-1:0] r;
		r = {1'b0, v};
		if (r < DIMX_W'(2)) r = DIMX_W'(2);
		if (r > hi) r = hi;
		return r;
	endfunction

	assign size_wr = cfg_we && (cfg_index == ypm_pkg::REG_WIDTH || cfg_index == ypm_pkg::REG_HEIGHT);
	assign w_src = (cfg_we && cfg_index == ypm_pkg::REG_WIDTH) ?
		cfg_data[ypm_pkg::DIM_W-1:0] : w_q;
	assign h_src = (cfg_we && cfg_index == ypm_pkg::REG_HEIGHT) ?
		cfg_data[ypm_pkg::DIM_W-1:0] : h_q;
	assign w_eff = clampd(w_src, DIMX_W'(MAX_WIDTH));
	assign h_eff = clampd(h_src, DIMX_W'(MAX_HEIGHT));
	assign luma_sz = SIZE_W'(w_eff * h_eff);
	assign uv_sz   = SIZE_W'(((h_eff >> 1) * w_eff) >> 1);

	assign plane_nx = (plane_q >= ypm_pkg::PLANE_V) ? ypm_pkg::PLANE_Y : plane_q + 1'b1;
	assign next_sz  = (plane_nx == ypm_pkg::PLANE_Y) ? luma_sz : uv_sz;

	assign diff_pix = (orig_pixel >= rec_pixel) ? orig_pixel - rec_pixel : rec_pixel - orig_pixel;
	assign sq       = diff_pix * diff_pix;
	assign acc_sum  = {1'b0, acc_q} + {{(ypm_pkg::ACC_W + 1 - 16){1'b0}}, sq};
	assign acc_next = acc_sum[ypm_pkg::ACC_W] ? ypm_pkg::ACC_MAX : acc_sum[ypm_pkg::ACC_W-1:0];

	assign last_pix = (left_q == SIZE_W'(1));
	assign frame_ok = (frame_q <= last_q);
	assign in_ready = !(last_pix && frame_ok && cmd.busy);
	assign accept   = in_valid && in_ready;

	assign sts.job_start = accept && last_pix && frame_ok;
	assign sts.job_zero  = (acc_next == '0);
	assign sts.x_msb     = x_q[X_W-1];

	assign t_sq  = p_q[SQ_W-1:ypm_pkg::MANT_W-1];
	assign d_val = (ln_q > r_q) ? ln_q - r_q : '0;
	assign rnd   = {1'b0, prod_q} + (PROD_W + 1)'(64'd1 << 31);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q     <= ypm_pkg::DIM_W'(176);
			h_q     <= ypm_pkg::DIM_W'(144);
			last_q  <= ypm_pkg::FRAME_W'(65536);
			frame_q <= '0;
			plane_q <= ypm_pkg::PLANE_Y;
			left_q  <= SIZE_W'(RST_W * RST_H);
			acc_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ypm_pkg::REG_WIDTH:  w_q <= cfg_data[ypm_pkg::DIM_W-1:0];
				ypm_pkg::REG_HEIGHT: h_q <= cfg_data[ypm_pkg::DIM_W-1:0];
				ypm_pkg::REG_FIRST:  frame_q <= cfg_data;
				ypm_pkg::REG_LAST:   last_q <= cfg_data;
				default: ;
			endcase
			if (size_wr) begin
				plane_q <= ypm_pkg::PLANE_Y;
				acc_q   <= '0;
				left_q  <= luma_sz;
			end
		end else if (accept) begin
			if (last_pix) begin
				acc_q   <= '0;
				plane_q <= plane_nx;
				left_q  <= next_sz;
				if (plane_q >= ypm_pkg::PLANE_V && frame_q != ypm_pkg::FRAME_MAX)
					frame_q <= frame_q + 1'b1;
			end else begin
				acc_q  <= acc_next;
				left_q <= left_q - 1'b1;
			end
		end
	end

	// job capture and log2 difference engine
	always_ff @(posedge clk) begin
		if (sts.job_start) begin
			plane_id         <= plane_q;
			frame_index      <= frame_q;
			square_error_sum <= acc_next;
			perfect_match    <= sts.job_zero;
			psnr_db_q8       <= ypm_pkg::PSNR_MAX;
			cnt_q            <= (plane_q == ypm_pkg::PLANE_Y) ? luma_sz : uv_sz;
		end
		if (cmd.ld_num) begin
			x_q <= X_W'(ypm_pkg::PEAK_SQ) * X_W'(cnt_q);
			e_q <= E_W'(X_W - 1);
		end
		if (cmd.shift) begin
			x_q <= x_q << 1;
			e_q <= e_q - 1'b1;
		end
		if (cmd.take_m) begin
			m_q <= x_q[X_W-1 -: ypm_pkg::MANT_W];
			r_q <= {e_q, {ypm_pkg::FRAC_W{1'b0}}};
		end
		if (cmd.mul) p_q <= m_q * m_q;
		if (cmd.chk) begin
			if (t_sq[31]) begin
				m_q <= t_sq[31:1];
				r_q[cmd.bitsel] <= 1'b1;
			end else begin
				m_q <= t_sq[30:0];
			end
		end
		if (cmd.save_ln) begin
			ln_q <= r_q;
			x_q  <= X_W'(square_error_sum);
			e_q  <= E_W'(X_W - 1);
		end
		if (cmd.diff) prod_q <= d_val * ypm_pkg::LOG_K;
		if (cmd.scale) begin
			if (rnd[PROD_W:32] > (PROD_W - 31)'(ypm_pkg::PSNR_MAX))
				psnr_db_q8 <= ypm_pkg::PSNR_MAX;
			else
				psnr_db_q8 <= rnd[32 +: ypm_pkg::PSNR_W];
		end
	end

endmodule
